@@ hdl/smrc_pkg.sv @@
// Shared constants and the half-step coil table of the stepper ramp controller.
`default_nettype none
package smrc_pkg;

	localparam int DefaultMaxAngle  = 3600;
	localparam int DefaultRampSteps = 50;

	localparam int AngleW  = 12;
	localparam int StepW   = 16;
	localparam int PeriodW = 16;
	localparam int CoilW   = 4;
	localparam int PhaseW  = 3;
	localparam int ProdW   = 32;

	localparam logic [PeriodW-1:0] SlowestUs = 16'd65535;
	localparam logic [PeriodW-1:0] FastestUs = 16'd1250;
	localparam logic [PeriodW-1:0] SpanUs    = 16'd64285;

	// 512 half steps per 45 degrees: steps = angle * 512 / 45.
	localparam int AngleShift = 9;
	localparam logic [StepW-1:0] DegPerBlock = 16'd45;

	function automatic logic [CoilW-1:0] coil_for(input logic [PhaseW-1:0] phase);
		logic [CoilW-1:0] c;
		unique case (phase)
			3'd0: c = 4'd1;
			3'd1: c = 4'd3;
			3'd2: c = 4'd2;
			3'd3: c = 4'd6;
			3'd4: c = 4'd4;
			3'd5: c = 4'd12;
			3'd6: c = 4'd8;
			3'd7: c = 4'd9;
			default: c = 4'd0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

@@ hdl/stepper_move_ramp_controller.sv @@
// Top level of the half-step stepper sequencer with a speed ramp.
//
//  Channel | Handshake                   | Payload
//  --------+-----------------------------+------------------------------------------------
//  item    | item_valid / item_ready     | mode, angle_deg, direction
//  result  | result_valid / result_ready | coil_pattern, step_period_us, period_changed, running
//
// One transaction is in work at a time; item_ready is high only in IDLE.
// A start transaction runs the bit-serial divider (one quotient bit per cycle),
// posts its result and returns to IDLE.
// A tick in the ramp-up or slow-down part of a move runs the shift-add
// multiplier, forms the dividend, runs the divider, posts and returns to IDLE.
// Other ticks (cruise, retire, stopped, nothing to do) go straight to the post state.
// Reset clears all move state; a stalled result holds the block in its post
// state, but the result register frees as soon as the result is taken.
`default_nettype none
module stepper_move_ramp_controller #(
	parameter int MAX_ANGLE  = smrc_pkg::DefaultMaxAngle,
	parameter int RAMP_STEPS = smrc_pkg::DefaultRampSteps
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic                          mode,
	input  wire logic [smrc_pkg::AngleW-1:0]   angle_deg,
	input  wire logic                          direction,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [smrc_pkg::CoilW-1:0]         coil_pattern,
	output logic [smrc_pkg::PeriodW-1:0]       step_period_us,
	output logic                               period_changed,
	output logic                               running
);

	localparam int StepW   = smrc_pkg::StepW;
	localparam int PeriodW = smrc_pkg::PeriodW;
	localparam int ProdW   = smrc_pkg::ProdW;
	localparam int CntW    = $clog2(ProdW);
	localparam logic [CntW-1:0] MulLast = CntW'(StepW - 1);
	localparam logic [CntW-1:0] DivLast = CntW'(ProdW - 1);

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADJ, S_DIV, S_FIN} state_t;
	// What the transaction in work will post.
	typedef enum logic [1:0] {OP_START, OP_STEP, OP_HOLD} op_t;
	// Which part of the speed profile the step falls in.
	typedef enum logic [1:0] {BR_RAMP, BR_SLOW, BR_FLAT, BR_SAT} branch_t;

	state_t  state_q;
	op_t     op_q;
	branch_t br_q;
	logic [CntW-1:0] cnt_q;

	// Move state.
	logic [smrc_pkg::PhaseW-1:0] phase_q;
	logic [StepW-1:0]            total_q;
	logic [StepW-1:0]            remaining_q;
	logic [StepW-1:0]            done_q;
	logic                        finish_q;
	logic [PeriodW-1:0]          last_period_q;
	logic                        dir_q;
	logic                        enabled_q;
	logic [smrc_pkg::CoilW-1:0]  coil_q;

	// Result register.
	logic                        out_valid_q;
	logic [smrc_pkg::CoilW-1:0]  coil_out_q;
	logic [PeriodW-1:0]          period_out_q;
	logic                        changed_out_q;
	logic                        running_out_q;

	// Serial datapath: shift-add multiplier and restoring divider; the product is loaded into the dividend register.
	logic [StepW-1:0] acc_hi_q;
	logic [StepW-1:0] mul_q;
	logic [ProdW-1:0] dvd_q;
	logic [StepW-1:0] dsr_q;
	logic [StepW-1:0] rem_q;

	logic accept;
	logic post;
	logic [StepW-1:0] rem0;
	logic [StepW-1:0] n_next;
	logic [smrc_pkg::AngleW-1:0] angle_c;
	branch_t br_next;
	logic [StepW:0] mul_sum;
	logic [StepW:0] trial;
	logic [StepW:0] diff;
	logic           q_bit;
	logic [PeriodW-1:0] period_new;
	logic [StepW-1:0]   total_new;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign post       = (state_q == S_FIN) && (!out_valid_q || result_ready);

	assign result_valid   = out_valid_q;
	assign coil_pattern   = coil_out_q;
	assign step_period_us = period_out_q;
	assign period_changed = changed_out_q;
	assign running        = running_out_q;

	always_comb begin
		// A tick first reloads an empty remaining count from the total.
		rem0    = (remaining_q == '0) ? total_q : remaining_q;
		n_next  = (done_q == '1) ? done_q : StepW'(done_q + 1'b1);
		angle_c = ({1'b0, angle_deg} > 13'(MAX_ANGLE)) ? smrc_pkg::AngleW'(MAX_ANGLE)
			: angle_deg;
		if (n_next <= StepW'(RAMP_STEPS)) begin
			br_next = BR_RAMP;
		end else if (({1'b0, n_next} + (StepW+1)'(RAMP_STEPS)) >= {1'b0, total_q}) begin
			br_next = (total_q == '0) ? BR_SAT : BR_SLOW;
		end else begin
			br_next = BR_FLAT;
		end
	end

	always_comb begin
		mul_sum = {1'b0, acc_hi_q} + (mul_q[0] ? {1'b0, smrc_pkg::SpanUs} : '0);
		trial   = {rem_q, dvd_q[ProdW-1]};
		diff    = trial - {1'b0, dsr_q};
		q_bit   = (trial >= {1'b0, dsr_q});
	end

	always_comb begin
		total_new = (|dvd_q[ProdW-1:StepW]) ? '1 : dvd_q[StepW-1:0];
		unique case (br_q)
			BR_RAMP: period_new = smrc_pkg::SlowestUs - dvd_q[StepW-1:0];
			BR_SLOW: begin
				// 1250 + quotient, saturated at the slowest period.
				if (dvd_q > ProdW'(smrc_pkg::SlowestUs - smrc_pkg::FastestUs)) begin
					period_new = smrc_pkg::SlowestUs;
				end else begin
					period_new = smrc_pkg::FastestUs + dvd_q[PeriodW-1:0];
				end
			end
			BR_FLAT: period_new = smrc_pkg::FastestUs;
			BR_SAT:  period_new = smrc_pkg::SlowestUs;
			default: period_new = smrc_pkg::SlowestUs;
		endcase
	end

	// Control, move state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_HOLD;
			br_q          <= BR_FLAT;
			cnt_q         <= '0;
			phase_q       <= '0;
			total_q       <= '0;
			remaining_q   <= '0;
			done_q        <= '0;
			finish_q      <= 1'b0;
			last_period_q <= '0;
			dir_q         <= 1'b0;
			enabled_q     <= 1'b0;
			coil_q        <= '0;
			out_valid_q   <= 1'b0;
			coil_out_q    <= '0;
			period_out_q  <= '0;
			changed_out_q <= 1'b0;
			running_out_q <= 1'b0;
		end else begin
			if (out_valid_q && result_ready && !post) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (!mode) begin
							// Start: the total arrives from the divider.
							op_q      <= OP_START;
							dir_q     <= direction;
							enabled_q <= 1'b1;
							state_q   <= S_DIV;
						end else if (!enabled_q) begin
							op_q    <= OP_HOLD;
							state_q <= S_FIN;
						end else if (finish_q) begin
							// The tick after the last step retires the move.
							op_q        <= OP_HOLD;
							finish_q    <= 1'b0;
							enabled_q   <= 1'b0;
							remaining_q <= '0;
							coil_q      <= '0;
							done_q      <= '0;
							total_q     <= '0;
							state_q     <= S_FIN;
						end else if (rem0 == '0) begin
							op_q    <= OP_HOLD;
							state_q <= S_FIN;
						end else begin
							op_q <= OP_STEP;
							br_q <= br_next;
							if (rem0 == StepW'(1)) begin
								finish_q    <= 1'b1;
								remaining_q <= rem0;
							end else begin
								remaining_q <= StepW'(rem0 - 1'b1);
							end
							done_q  <= n_next;
							coil_q  <= smrc_pkg::coil_for(phase_q);
							phase_q <= dir_q ? 3'(phase_q + 3'd1) : 3'(phase_q - 3'd1);
							// Cruise and zero-total periods need no arithmetic.
							state_q <= (br_next == BR_RAMP || br_next == BR_SLOW) ? S_MUL
								: S_FIN;
						end
					end
				end
				S_MUL: begin
					cnt_q <= CntW'(cnt_q + 1'b1);
					if (cnt_q == MulLast) begin
						state_q <= S_ADJ;
					end
				end
				S_ADJ: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= CntW'(cnt_q + 1'b1);
					if (cnt_q == DivLast) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (post) begin
						out_valid_q   <= 1'b1;
						running_out_q <= enabled_q;
						coil_out_q    <= coil_q;
						if (op_q == OP_START) begin
							total_q <= total_new;
						end
						if (op_q == OP_STEP) begin
							period_out_q  <= period_new;
							changed_out_q <= (period_new != last_period_q);
							last_period_q <= period_new;
						end else begin
							period_out_q  <= last_period_q;
							changed_out_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Serial datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rem_q <= '0;
				if (accept && !mode) begin
					dvd_q <= {{(ProdW-smrc_pkg::AngleW-smrc_pkg::AngleShift){1'b0}},
						angle_c, {smrc_pkg::AngleShift{1'b0}}};
					dsr_q <= smrc_pkg::DegPerBlock;
				end
				acc_hi_q <= '0;
				mul_q    <= n_next;
			end
			S_MUL: begin
				// Shift-add: one multiplier bit per cycle, product shifts right.
				acc_hi_q <= mul_sum[StepW:1];
				mul_q    <= {mul_sum[0], mul_q[StepW-1:1]};
			end
			S_ADJ: begin
				rem_q <= '0;
				if (br_q == BR_RAMP) begin
					// Rounding up: add divisor minus one before dividing.
					dvd_q <= {acc_hi_q, mul_q} + ProdW'(RAMP_STEPS - 1);
					dsr_q <= StepW'(RAMP_STEPS);
				end else begin
					dvd_q <= {acc_hi_q, mul_q};
					dsr_q <= total_q;
				end
			end
			S_DIV: begin
				// Restoring division: quotient bits shift in behind the dividend.
				rem_q <= q_bit ? diff[StepW-1:0] : trial[StepW-1:0];
				dvd_q <= {dvd_q[ProdW-2:0], q_bit};
			end
			S_FIN: begin
				rem_q <= rem_q;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/smrc_checker.sv @@
// Port-level checker for the stepper ramp controller and its bind statement.
`default_nettype none
module smrc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          item_valid,
	input wire logic                          item_ready,
	input wire logic                          result_valid,
	input wire logic                          result_ready,
	input wire logic [smrc_pkg::CoilW-1:0]    coil_pattern,
	input wire logic [smrc_pkg::PeriodW-1:0]  step_period_us,
	input wire logic                          period_changed,
	input wire logic                          running
);

	// A stalled result keeps its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(coil_pattern)
			&& $stable(step_period_us) && $stable(period_changed) && $stable(running))
		else $error("result changed while stalled");

	// Coils are only driven during a move.
	a_coils_off: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !running |-> coil_pattern == '0)
		else $error("coils driven while stopped");

	// A new period is only computed by a step, which leaves the timer running.
	a_change_running: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && period_changed |-> running)
		else $error("period changed while stopped");

	a_period_floor: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && period_changed |-> step_period_us >= smrc_pkg::FastestUs)
		else $error("new period below the fastest period");

	// An accepted transaction takes the block out of IDLE, so item_ready falls after acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken on consecutive cycles");

endmodule

bind stepper_move_ramp_controller smrc_checker u_smrc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_ready     (item_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.coil_pattern   (coil_pattern),
	.step_period_us (step_period_us),
	.period_changed (period_changed),
	.running        (running)
);
`default_nettype wire
